@@ rtl/sdr_pkg.sv @@
package sdr_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIVZ = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } sdr_cmd_t;

  typedef struct packed {
    logic last_step;
  } sdr_sts_t;

endpackage

@@ rtl/sdr_dp.sv @@
module sdr_dp
  import sdr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  sdr_cmd_t                     cmd,
  output sdr_sts_t                     sts,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic signed [DATA_WIDTH-1:0] remainder,
  output logic [1:0]                   status
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [DATA_WIDTH-1:0] dividend_r;
  logic                  neg_q_r;
  logic                  neg_r_r;
  logic                  divz_r;
  logic                  ovf_r;
  logic [CNT_W-1:0]      cnt_r;

  logic signed [DATA_WIDTH-1:0] quotient_r;
  logic signed [DATA_WIDTH-1:0] remainder_r;
  logic [1:0]                   status_r;

  logic [DATA_WIDTH-1:0] ua;
  logic [DATA_WIDTH-1:0] ub;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  ge;

  always_comb begin
    ua      = dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-dividend) : DATA_WIDTH'(dividend);
    ub      = divisor[DATA_WIDTH-1] ? DATA_WIDTH'(-divisor) : DATA_WIDTH'(divisor);
    shifted = {rem_r, quo_r[DATA_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~diff[DATA_WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r      <= '0;
      quo_r      <= ua;
      dvs_r      <= ub;
      dividend_r <= dividend;
      neg_q_r    <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      neg_r_r    <= dividend[DATA_WIDTH-1];
      divz_r     <= (divisor == '0);
      ovf_r      <= (dividend == MIN_VAL) && (divisor == ALL_ONES);
      cnt_r      <= CNT_W'(DATA_WIDTH - 1);
    end else if (cmd.step) begin
      rem_r <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_r <= {quo_r[DATA_WIDTH-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (divz_r) begin
        quotient_r  <= '0;
        remainder_r <= dividend_r;
        status_r    <= STATUS_DIVZ;
      end else begin
        quotient_r  <= neg_q_r ? -quo_r : quo_r;
        remainder_r <= neg_r_r ? -rem_r : rem_r;
        status_r    <= ovf_r ? STATUS_OVF : STATUS_OK;
      end
    end
  end

  assign sts.last_step = (cnt_r == '0);
  assign quotient      = quotient_r;
  assign remainder     = remainder_r;
  assign status        = status_r;

endmodule

@@ rtl/sdr_ctrl.sv @@
module sdr_ctrl
  import sdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output sdr_cmd_t cmd,
  input  sdr_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free  = ~out_valid_r | out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CALC))
    else $error("transfer in did not start iteration");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending transfer");

  a_last_step_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && sts.last_step) |=> (state_r == ST_FIX))
    else $error("iteration did not end in fixup");

  a_valid_from_fix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIX))
    else $error("result valid without fixup");

endmodule

@@ rtl/signed_divide_remainder_core.sv @@
// Signed truncating divider. One result follows each input transfer. An item
// passes a load step that takes operand magnitudes, DATA_WIDTH steps of the
// radix-2 restoring loop that forms one quotient bit each, and a sign fixup
// step that writes the output register once that register is free; a new
// item is taken only after that fixup. The output register lets the next
// item be taken while a result still waits. Divide by zero gives
// quotient 0, remainder equal to the dividend and status 1; most-negative by
// minus one gives the most-negative quotient, remainder 0 and status 2.
module signed_divide_remainder_core
  import sdr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    in_tdata,   // dividend, divisor
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    out_tdata,  // quotient, remainder
  output logic [1:0]                           out_tuser   // status
);

  localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;

  sdr_cmd_t cmd;
  sdr_sts_t sts;

  logic signed [DATA_WIDTH-1:0] quotient;
  logic signed [DATA_WIDTH-1:0] remainder;

  sdr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sdr_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .dividend  (in_tdata[DATA_WIDTH-1:0]),
    .divisor   (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (out_tuser)
  );

  assign out_tdata = TDATA_W'({remainder, quotient});

endmodule
